FILE: rtl/jdsm_pkg.sv
`timescale 1ns / 1ps

package jdsm_pkg;

   localparam int SAMPLE_BITS_DEF = 11;
   localparam int LANES = 4;
   localparam int SPEED_BITS = 7;
   localparam int CSR_INDEX_BITS = 2;

   localparam int LANE_PAN = 0;
   localparam int LANE_TILT = 1;
   localparam int LANE_ZOOM = 2;
   localparam int LANE_FOCUS = 3;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_CENTER = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEADZONE = 2'd3;

   localparam int CENTER_RESET = 1010;
   localparam int MAX_RESET = 1800;
   localparam int MIN_RESET = 200;
   localparam int DEADZONE_RESET = 50;

   localparam logic [SPEED_BITS-1:0] STOP_CODE = 7'd50;
   localparam logic [SPEED_BITS-1:0] NEG_LOW = 7'd1;
   localparam logic [SPEED_BITS-1:0] POS_LOW = 7'd51;
   // both sides cover 49 codes: 1..49 and 51..99
   localparam logic [SPEED_BITS-1:0] QUO_CAP = 7'd48;

   // quotient bits resolved by the divider, one per cycle
   localparam int QUO_BITS = 6;
   localparam int QUO_IDX_BITS = $clog2(QUO_BITS);

   typedef struct packed {
      logic                    load;
      logic                    offs;
      logic                    setup;
      logic                    step;
      logic [QUO_IDX_BITS-1:0] bit_idx;
   } jdsm_ctl_type;

endpackage

FILE: rtl/joystick_deadzone_speed_mapper_unit.sv
`timescale 1ns / 1ps

// stick dead zone and speed code mapper, four lanes (pan, tilt, zoom, focus)
// req channel: one beat carries the four raw samples, valid/ready handshake
// rsp channel: one beat per request with four speed codes (50 stop, 1..49
// negative, 51..99 positive) and the pan/tilt, zoom and focus change flags
// csr port: csr_wr_en writes csr_data into register csr_index (center, max,
// min, dead zone) at once; write only while no request is in flight
// each lane clamps its offset, then runs a restoring divider that resolves
// one quotient bit per cycle; the four lanes run in lockstep
// a new request is taken only after offset, setup, six divide steps, merge
// and the return to idle
// the output register holds a finished beat while the next request runs;
// if rsp_ready stays low the merge step waits and req_ready stays low
// reset: registers return to 1010 / 1800 / 200 / 50, stored speeds clear to
// zero so the first beat raises all change flags, no beat is pending
module joystick_deadzone_speed_mapper_unit #(
   parameter int SAMPLE_BITS = jdsm_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [SAMPLE_BITS-1:0]                req_pan_sample,
   input  logic [SAMPLE_BITS-1:0]                req_tilt_sample,
   input  logic [SAMPLE_BITS-1:0]                req_zoom_sample,
   input  logic [SAMPLE_BITS-1:0]                req_focus_sample,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [jdsm_pkg::SPEED_BITS-1:0]       rsp_pan_speed,
   output logic [jdsm_pkg::SPEED_BITS-1:0]       rsp_tilt_speed,
   output logic [jdsm_pkg::SPEED_BITS-1:0]       rsp_zoom_speed,
   output logic [jdsm_pkg::SPEED_BITS-1:0]       rsp_focus_speed,
   output logic                                  rsp_pan_tilt_changed,
   output logic                                  rsp_zoom_changed,
   output logic                                  rsp_focus_changed,
   input  logic                                  csr_wr_en,
   input  logic [jdsm_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [SAMPLE_BITS-1:0]                csr_data
);
   import jdsm_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_OFFS,
      ST_SETUP,
      ST_DIV,
      ST_MERGE
   } state_type;

   state_type               state_ff;
   logic [QUO_IDX_BITS-1:0] step_ff;
   logic [SAMPLE_BITS-1:0]  center_ff, max_ff, min_ff, deadzone_ff;

   jdsm_ctl_type          ctl;
   logic                  accept;
   logic                  merge_load;
   logic [SAMPLE_BITS-1:0] samples [LANES];
   logic [SPEED_BITS-1:0]  speeds [LANES];

   assign req_ready = (state_ff == ST_IDLE);
   assign accept = req_valid && req_ready;
   assign merge_load = (state_ff == ST_MERGE) && (!rsp_valid || rsp_ready);

   always_comb begin
      ctl.load = accept;
      ctl.offs = (state_ff == ST_OFFS);
      ctl.setup = (state_ff == ST_SETUP);
      ctl.step = (state_ff == ST_DIV);
      ctl.bit_idx = step_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff <= '0;
         center_ff <= SAMPLE_BITS'(CENTER_RESET);
         max_ff <= SAMPLE_BITS'(MAX_RESET);
         min_ff <= SAMPLE_BITS'(MIN_RESET);
         deadzone_ff <= SAMPLE_BITS'(DEADZONE_RESET);
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_CENTER: center_ff <= csr_data;
               CSR_MAX: max_ff <= csr_data;
               CSR_MIN: min_ff <= csr_data;
               CSR_DEADZONE: deadzone_ff <= csr_data;
               default: ;
            endcase
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  state_ff <= ST_OFFS;
               end
            end
            ST_OFFS: state_ff <= ST_SETUP;
            ST_SETUP: begin
               state_ff <= ST_DIV;
               step_ff <= QUO_IDX_BITS'(QUO_BITS - 1);
            end
            ST_DIV: begin
               if (step_ff == '0) begin
                  state_ff <= ST_MERGE;
               end else begin
                  step_ff <= step_ff - 1'b1;
               end
            end
            ST_MERGE: begin
               if (merge_load) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign samples[LANE_PAN] = req_pan_sample;
   assign samples[LANE_TILT] = req_tilt_sample;
   assign samples[LANE_ZOOM] = req_zoom_sample;
   assign samples[LANE_FOCUS] = req_focus_sample;

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      jdsm_lane #(
         .SAMPLE_BITS(SAMPLE_BITS)
      ) u_lane (
         .clock         (clock),
         .ctl           (ctl),
         .sample        (samples[g]),
         .center_level  (center_ff),
         .max_level     (max_ff),
         .min_level     (min_ff),
         .deadzone_width(deadzone_ff),
         .speed         (speeds[g])
      );
   end

   jdsm_merge u_merge (
      .clock               (clock),
      .reset               (reset),
      .load                (merge_load),
      .lane_speed          (speeds),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_pan_speed       (rsp_pan_speed),
      .rsp_tilt_speed      (rsp_tilt_speed),
      .rsp_zoom_speed      (rsp_zoom_speed),
      .rsp_focus_speed     (rsp_focus_speed),
      .rsp_pan_tilt_changed(rsp_pan_tilt_changed),
      .rsp_zoom_changed    (rsp_zoom_changed),
      .rsp_focus_changed   (rsp_focus_changed)
   );

endmodule

FILE: rtl/jdsm_lane.sv
`timescale 1ns / 1ps

module jdsm_lane #(
   parameter int SAMPLE_BITS = jdsm_pkg::SAMPLE_BITS_DEF
) (
   input  logic                             clock,
   input  jdsm_pkg::jdsm_ctl_type           ctl,
   input  logic [SAMPLE_BITS-1:0]           sample,
   input  logic [SAMPLE_BITS-1:0]           center_level,
   input  logic [SAMPLE_BITS-1:0]           max_level,
   input  logic [SAMPLE_BITS-1:0]           min_level,
   input  logic [SAMPLE_BITS-1:0]           deadzone_width,
   output logic [jdsm_pkg::SPEED_BITS-1:0]  speed
);
   import jdsm_pkg::*;

   localparam int SW = SAMPLE_BITS + 3;
   localparam int MW = SAMPLE_BITS + 7;
   localparam int DW = SAMPLE_BITS + 1;

   logic [SAMPLE_BITS-1:0] sample_ff;
   logic signed [SW-1:0]   off_ff;
   logic [MW-1:0]          rem_ff;
   logic [DW-1:0]          div_ff;
   logic [QUO_BITS-1:0]    quo_ff;
   logic                   ovf_ff;
   logic                   stop_ff;
   logic                   flip_ff;
   logic                   pos_ff;

   logic signed [SW-1:0] s_x, c_x, d_x, lo_x, hi_x;
   logic signed [SW-1:0] raw_off, off_in;
   logic signed [SW-1:0] num_a, den_b;
   logic [SW-1:0]        amag, bmag;
   logic [MW-1:0]        nmag_in;
   logic [MW-1:0]        trial;
   logic                 neg_side;
   logic [SPEED_BITS-1:0] base;

   assign s_x = signed'(SW'(sample_ff));
   assign c_x = signed'(SW'(center_level));
   assign d_x = signed'(SW'(deadzone_width));
   assign lo_x = signed'(SW'(min_level)) - c_x;
   assign hi_x = signed'(SW'(max_level)) - c_x;

   // dead zone, then clamp with the lower bound checked first
   always_comb begin
      if (s_x <= c_x - d_x || s_x >= c_x + d_x) begin
         raw_off = s_x - c_x;
      end else begin
         raw_off = '0;
      end
      if (raw_off <= lo_x) begin
         off_in = lo_x;
      end else if (raw_off >= hi_x) begin
         off_in = hi_x;
      end else begin
         off_in = raw_off;
      end
   end

   // numerator and span of the side picked by the offset sign
   always_comb begin
      neg_side = off_ff < 0;
      num_a = neg_side ? off_ff - lo_x : off_ff;
      den_b = neg_side ? -lo_x : hi_x;
      amag = (num_a < 0) ? SW'(-num_a) : SW'(num_a);
      bmag = (den_b < 0) ? SW'(-den_b) : SW'(den_b);
      nmag_in = (MW'(amag) << 5) + (MW'(amag) << 4);
   end

   assign trial = MW'(div_ff) << ctl.bit_idx;

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         sample_ff <= sample;
      end
      if (ctl.offs) begin
         off_ff <= off_in;
      end
      if (ctl.setup) begin
         rem_ff <= nmag_in;
         div_ff <= DW'(bmag);
         quo_ff <= '0;
         ovf_ff <= nmag_in >= (MW'(bmag) << QUO_BITS);
         stop_ff <= (off_ff == 0) || (bmag == '0);
         flip_ff <= (num_a != 0) && ((num_a < 0) != (den_b < 0));
         pos_ff <= !neg_side;
      end
      if (ctl.step && rem_ff >= trial) begin
         rem_ff <= rem_ff - trial;
         quo_ff[ctl.bit_idx] <= 1'b1;
      end
   end

   always_comb begin
      base = pos_ff ? POS_LOW : NEG_LOW;
      if (stop_ff) begin
         speed = STOP_CODE;
      end else if (flip_ff) begin
         speed = base;
      end else if (ovf_ff || SPEED_BITS'(quo_ff) > QUO_CAP) begin
         speed = base + QUO_CAP;
      end else begin
         speed = base + SPEED_BITS'(quo_ff);
      end
   end

endmodule

FILE: rtl/jdsm_merge.sv
`timescale 1ns / 1ps

module jdsm_merge (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            load,
   input  logic [jdsm_pkg::SPEED_BITS-1:0] lane_speed [jdsm_pkg::LANES],
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [jdsm_pkg::SPEED_BITS-1:0] rsp_pan_speed,
   output logic [jdsm_pkg::SPEED_BITS-1:0] rsp_tilt_speed,
   output logic [jdsm_pkg::SPEED_BITS-1:0] rsp_zoom_speed,
   output logic [jdsm_pkg::SPEED_BITS-1:0] rsp_focus_speed,
   output logic                            rsp_pan_tilt_changed,
   output logic                            rsp_zoom_changed,
   output logic                            rsp_focus_changed
);
   import jdsm_pkg::*;

   logic [SPEED_BITS-1:0] last_ff [LANES];
   logic [SPEED_BITS-1:0] speed_ff [LANES];
   logic                  valid_ff;
   logic                  pt_chg_ff, zoom_chg_ff, focus_chg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         for (int i = 0; i < LANES; i++) begin
            last_ff[i] <= '0;
         end
      end else if (load) begin
         valid_ff <= 1'b1;
         for (int i = 0; i < LANES; i++) begin
            last_ff[i] <= lane_speed[i];
         end
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
      if (load) begin
         for (int i = 0; i < LANES; i++) begin
            speed_ff[i] <= lane_speed[i];
         end
         pt_chg_ff <= (lane_speed[LANE_PAN] != last_ff[LANE_PAN])
                   || (lane_speed[LANE_TILT] != last_ff[LANE_TILT]);
         zoom_chg_ff <= lane_speed[LANE_ZOOM] != last_ff[LANE_ZOOM];
         focus_chg_ff <= lane_speed[LANE_FOCUS] != last_ff[LANE_FOCUS];
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_pan_speed = speed_ff[LANE_PAN];
   assign rsp_tilt_speed = speed_ff[LANE_TILT];
   assign rsp_zoom_speed = speed_ff[LANE_ZOOM];
   assign rsp_focus_speed = speed_ff[LANE_FOCUS];
   assign rsp_pan_tilt_changed = pt_chg_ff;
   assign rsp_zoom_changed = zoom_chg_ff;
   assign rsp_focus_changed = focus_chg_ff;

endmodule

FILE: tb/tb_joystick_deadzone_speed_mapper_unit.sv
`timescale 1ns / 1ps

module tb_joystick_deadzone_speed_mapper_unit;
   import jdsm_pkg::*;

   localparam int SAMPLE_BITS = SAMPLE_BITS_DEF;
   localparam int LEVEL_TOP = (1 << SAMPLE_BITS) - 1;
   localparam int NEG_TOP = 49;
   localparam int POS_TOP = 99;
   localparam int CODE_STEPS = 48;
   localparam int MAX_IDLE = 13;
   localparam int SETTLE_CYCLES = 12;

   typedef logic [SAMPLE_BITS-1:0] level_type;
   typedef logic [SPEED_BITS-1:0] speed_type;

   typedef struct packed {
      speed_type pan;
      speed_type tilt;
      speed_type zoom;
      speed_type focus;
      logic      pan_tilt_chg;
      logic      zoom_chg;
      logic      focus_chg;
   } speed_beat_type;

   logic      clock;
   logic      reset;
   logic      req_valid;
   logic      req_ready;
   level_type req_pan_sample;
   level_type req_tilt_sample;
   level_type req_zoom_sample;
   level_type req_focus_sample;
   logic      rsp_valid;
   logic      rsp_ready;
   speed_type rsp_pan_speed;
   speed_type rsp_tilt_speed;
   speed_type rsp_zoom_speed;
   speed_type rsp_focus_speed;
   logic      rsp_pan_tilt_changed;
   logic      rsp_zoom_changed;
   logic      rsp_focus_changed;
   logic      csr_wr_en;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   level_type csr_data;

   // calibration and stored speeds as the block should hold them
   int        center_lvl;
   int        max_lvl;
   int        min_lvl;
   int        dz_lvl;
   speed_type stored_speed [LANES];
   level_type last_frame [LANES];

   speed_beat_type speeds_due[$];
   int             errors;
   bit             reset_done;
   bit             no_idle;

   joystick_deadzone_speed_mapper_unit #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_pan_sample(req_pan_sample),
      .req_tilt_sample(req_tilt_sample),
      .req_zoom_sample(req_zoom_sample),
      .req_focus_sample(req_focus_sample),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_pan_speed(rsp_pan_speed),
      .rsp_tilt_speed(rsp_tilt_speed),
      .rsp_zoom_speed(rsp_zoom_speed),
      .rsp_focus_speed(rsp_focus_speed),
      .rsp_pan_tilt_changed(rsp_pan_tilt_changed),
      .rsp_zoom_changed(rsp_zoom_changed),
      .rsp_focus_changed(rsp_focus_changed),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(5_000_000);
      $display("tb_joystick_deadzone_speed_mapper_unit: FAIL");
      $finish;
   end

   function automatic speed_type speed_for_sample(input level_type sample);
      int s;
      int lo;
      int hi;
      int off;
      int span;
      int q;
      s = int'(sample);
      lo = min_lvl - center_lvl;
      hi = max_lvl - center_lvl;
      if (s <= center_lvl - dz_lvl || s >= center_lvl + dz_lvl) off = s - center_lvl;
      else off = 0;
      if (off <= lo) off = lo;
      else if (off >= hi) off = hi;
      if (off < 0) begin
         span = -lo;
         if (span == 0) return STOP_CODE;
         q = (off - lo) * CODE_STEPS / span + int'(NEG_LOW);
         if (q < int'(NEG_LOW)) q = int'(NEG_LOW);
         if (q > NEG_TOP) q = NEG_TOP;
         return speed_type'(q);
      end
      if (off == 0) return STOP_CODE;
      span = hi;
      if (span == 0) return STOP_CODE;
      q = off * CODE_STEPS / span + int'(POS_LOW);
      if (q < int'(POS_LOW)) q = int'(POS_LOW);
      if (q > POS_TOP) q = POS_TOP;
      return speed_type'(q);
   endfunction

   function automatic int idle_draw();
      if (no_idle) return 0;
      return int'($urandom_range(0, MAX_IDLE));
   endfunction

   function automatic level_type pick_sample(input level_type prev);
      int v;
      case ($urandom_range(0, 7))
         0, 1: v = int'($urandom_range(0, LEVEL_TOP));
         2: v = center_lvl + int'($urandom_range(0, 2 * dz_lvl + 4)) - dz_lvl - 2;
         3: v = min_lvl + int'($urandom_range(0, 8)) - 4;
         4: v = max_lvl + int'($urandom_range(0, 8)) - 4;
         5: v = center_lvl;
         6: v = $urandom_range(0, 1) ? LEVEL_TOP : 0;
         default: v = int'(prev);
      endcase
      if (v < 0) v = 0;
      if (v > LEVEL_TOP) v = LEVEL_TOP;
      return level_type'(v);
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // entered and left at a rising edge; leaves req_valid high after the beat
   task automatic send_frame(input level_type p, input level_type t, input level_type z,
                             input level_type f);
      int             gap;
      speed_beat_type due;
      gap = idle_draw();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pan_sample <= p;
      req_tilt_sample <= t;
      req_zoom_sample <= z;
      req_focus_sample <= f;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      due.pan = speed_for_sample(p);
      due.tilt = speed_for_sample(t);
      due.zoom = speed_for_sample(z);
      due.focus = speed_for_sample(f);
      due.pan_tilt_chg = (due.pan != stored_speed[LANE_PAN]) ||
                         (due.tilt != stored_speed[LANE_TILT]);
      due.zoom_chg = due.zoom != stored_speed[LANE_ZOOM];
      due.focus_chg = due.focus != stored_speed[LANE_FOCUS];
      stored_speed[LANE_PAN] = due.pan;
      stored_speed[LANE_TILT] = due.tilt;
      stored_speed[LANE_ZOOM] = due.zoom;
      stored_speed[LANE_FOCUS] = due.focus;
      last_frame[LANE_PAN] = p;
      last_frame[LANE_TILT] = t;
      last_frame[LANE_ZOOM] = z;
      last_frame[LANE_FOCUS] = f;
      speeds_due.push_back(due);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (speeds_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure(input int c, input int mx, input int mn, input int dz);
      drain();
      csr_wr_en <= 1'b1;
      csr_index <= CSR_CENTER;
      csr_data <= level_type'(c);
      @(posedge clock);
      csr_index <= CSR_MAX;
      csr_data <= level_type'(mx);
      @(posedge clock);
      csr_index <= CSR_MIN;
      csr_data <= level_type'(mn);
      @(posedge clock);
      csr_index <= CSR_DEADZONE;
      csr_data <= level_type'(dz);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      center_lvl = c;
      max_lvl = mx;
      min_lvl = mn;
      dz_lvl = dz;
   endtask

   task automatic run_random_frames(input int count);
      level_type nf [LANES];
      for (int i = 0; i < count; i++) begin
         if (i % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 4) == 0) begin
            for (int l = 0; l < LANES; l++) nf[l] = last_frame[l];
         end else begin
            for (int l = 0; l < LANES; l++) nf[l] = pick_sample(last_frame[l]);
         end
         send_frame(nf[LANE_PAN], nf[LANE_TILT], nf[LANE_ZOOM], nf[LANE_FOCUS]);
      end
      no_idle = 1'b0;
   endtask

   task automatic test_default_calibration();
      send_frame(1010, 1010, 1010, 1010);
      send_frame(1010, 1010, 1010, 1010);
      send_frame(960, 1060, 961, 1059);
      send_frame(200, 1800, 0, 2047);
      send_frame(201, 1799, 600, 1400);
      send_frame(0, 0, 2047, 2047);
      send_frame(1010, 1010, 2047, 0);
      send_frame(1010, 1010, 2047, 0);
   endtask

   task automatic test_zero_deadzone();
      configure(1010, 1800, 200, 0);
      send_frame(1010, 1009, 1011, 1010);
      send_frame(1009, 1011, 1010, 1010);
      send_frame(1010, 1010, 1010, 1010);
   endtask

   task automatic test_zero_span();
      configure(1000, 1000, 1000, 20);
      send_frame(0, 2047, 1000, 990);
      send_frame(1020, 979, 500, 1500);
      configure(500, 500, 0, 0);
      send_frame(2047, 0, 500, 250);
      send_frame(501, 499, 1, 2046);
   endtask

   task automatic test_inverted_calibration();
      configure(1000, 600, 1500, 10);
      send_frame(0, 2047, 1000, 1200);
      send_frame(700, 1600, 995, 1005);
      configure(1000, 800, 500, 0);
      send_frame(2047, 0, 900, 1000);
   endtask

   task automatic test_extreme_registers();
      configure(0, LEVEL_TOP, 0, 0);
      send_frame(0, 2047, 1, 1024);
      configure(LEVEL_TOP, LEVEL_TOP, 0, LEVEL_TOP);
      send_frame(0, 2047, 1, 1024);
      configure(LEVEL_TOP, 0, LEVEL_TOP, LEVEL_TOP);
      send_frame(0, 2047, 1, 1024);
      configure(0, 0, LEVEL_TOP, LEVEL_TOP);
      send_frame(0, 2047, 1, 1024);
   endtask

   task automatic test_random_calibrated();
      int c;
      for (int ph = 0; ph < 12; ph++) begin
         c = int'($urandom_range(200, 1850));
         configure(c, int'($urandom_range(c, LEVEL_TOP)), int'($urandom_range(0, c)),
                   ($urandom_range(0, 5) == 0) ? int'($urandom_range(0, 400))
                                               : int'($urandom_range(0, 80)));
         run_random_frames(90);
      end
   endtask

   task automatic test_random_any_setting();
      int r [4];
      for (int ph = 0; ph < 10; ph++) begin
         for (int k = 0; k < 4; k++) begin
            case ($urandom_range(0, 5))
               0: r[k] = 0;
               1: r[k] = LEVEL_TOP;
               default: r[k] = int'($urandom_range(0, LEVEL_TOP));
            endcase
         end
         if (r[3] != 0 && r[3] != LEVEL_TOP && $urandom_range(0, 2) != 0)
            r[3] = int'($urandom_range(0, 64));
         configure(r[0], r[1], r[2], r[3]);
         run_random_frames(45);
      end
   endtask

   // result side: random stalls, check each beat against the oldest prediction
   initial begin
      int             stall;
      speed_beat_type got;
      speed_beat_type want;
      wait (reset_done);
      @(posedge clock);
      forever begin
         stall = idle_draw();
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(negedge clock); while (!rsp_valid);
         got.pan = rsp_pan_speed;
         got.tilt = rsp_tilt_speed;
         got.zoom = rsp_zoom_speed;
         got.focus = rsp_focus_speed;
         got.pan_tilt_chg = rsp_pan_tilt_changed;
         got.zoom_chg = rsp_zoom_changed;
         got.focus_chg = rsp_focus_changed;
         if (speeds_due.size() == 0) begin
            report_mismatch("unexpected rsp beat, pan_speed", got.pan, -1);
         end else begin
            want = speeds_due.pop_front();
            if (got.pan !== want.pan) report_mismatch("pan_speed", got.pan, want.pan);
            if (got.tilt !== want.tilt) report_mismatch("tilt_speed", got.tilt, want.tilt);
            if (got.zoom !== want.zoom) report_mismatch("zoom_speed", got.zoom, want.zoom);
            if (got.focus !== want.focus)
               report_mismatch("focus_speed", got.focus, want.focus);
            if (got.pan_tilt_chg !== want.pan_tilt_chg)
               report_mismatch("pan_tilt_changed", got.pan_tilt_chg, want.pan_tilt_chg);
            if (got.zoom_chg !== want.zoom_chg)
               report_mismatch("zoom_changed", got.zoom_chg, want.zoom_chg);
            if (got.focus_chg !== want.focus_chg)
               report_mismatch("focus_changed", got.focus_chg, want.focus_chg);
         end
         @(posedge clock);
      end
   end

   initial begin
      errors = 0;
      no_idle = 1'b0;
      reset_done = 1'b0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_pan_sample <= '0;
      req_tilt_sample <= '0;
      req_zoom_sample <= '0;
      req_focus_sample <= '0;
      rsp_ready <= 1'b0;
      csr_wr_en <= 1'b0;
      csr_index <= CSR_CENTER;
      csr_data <= '0;
      center_lvl = CENTER_RESET;
      max_lvl = MAX_RESET;
      min_lvl = MIN_RESET;
      dz_lvl = DEADZONE_RESET;
      for (int l = 0; l < LANES; l++) begin
         stored_speed[l] = '0;
         last_frame[l] = '0;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      reset_done = 1'b1;

      test_default_calibration();
      test_zero_deadzone();
      test_zero_span();
      test_inverted_calibration();
      test_extreme_registers();
      test_random_calibrated();
      test_random_any_setting();

      drain();
      repeat (20) @(posedge clock);
      if (errors == 0 && speeds_due.size() == 0) begin
         $display("tb_joystick_deadzone_speed_mapper_unit: PASS");
      end else begin
         $display("tb_joystick_deadzone_speed_mapper_unit: FAIL");
      end
      $finish;
   end

endmodule
